FILE: rtl/tmfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmfe_pkg;

  localparam int IN_W     = 24;
  localparam int DIF_W    = IN_W + 1;
  localparam int PROD_W   = 2 * DIF_W;
  localparam int DET_W    = PROD_W + 1;
  localparam int ADET_W   = PROD_W;
  localparam int NMAG_W   = PROD_W;
  localparam int SPLIT_W  = 25;
  localparam int PP_W     = IN_W + SPLIT_W;
  localparam int NPROD_W  = PP_W + SPLIT_W;
  localparam int STIFF_SH = 12;
  localparam int DVD_W    = NPROD_W + STIFF_SH + 1;
  localparam int DEN_W    = ADET_W + 1;
  localparam int OUT_W    = 48;
  localparam int Q_W      = OUT_W - 1;
  localparam int DIV_LAT  = Q_W + 2;

  localparam int MASS_SH   = 15;
  localparam int MASS_DEN  = 3 * (1 << MASS_SH);
  localparam int MASS_HALF = MASS_DEN / 2;

  localparam int JOBQ_DEPTH = 4;

  localparam int ROW_W = 2;
  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

  typedef logic signed [DIF_W-1:0] dif_t;

  // One classified triangle as handed from the front to the back.
  typedef struct packed {
    dif_t [2:0]              dy;
    dif_t [2:0]              dx;
    logic [ADET_W-1:0]       adet;
    logic                    sing;
    logic signed [IN_W-1:0]  alpha;
    logic signed [IN_W-1:0]  beta;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/tmfe_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tmfe_div
  import tmfe_pkg::*;
(
  input  wire              clk,
  input  wire [DVD_W-1:0]  dvd,
  input  wire [DEN_W-1:0]  den,
  input  wire              neg,
  output logic signed [OUT_W-1:0] res
);

  logic [DEN_W-1:0]   rem_r   [Q_W];
  logic [DEN_W-1:0]   rem_nxt [Q_W];
  logic [DEN_W-1:0]   den_r   [Q_W];
  logic [Q_W-1:0]     wrd_r   [Q_W+1];
  logic [Q_W-1:0]     wrd_nxt [Q_W+1];
  logic               sat_r   [Q_W+1];
  logic               neg_r   [Q_W+1];
  logic [DEN_W:0]     tr      [Q_W];
  logic               ge      [Q_W];
  logic [DVD_W-Q_W-1:0] dhi;
  logic               sat0;
  logic [OUT_W-1:0]   mag;
  logic signed [OUT_W-1:0] res_r;

  // The leading dividend bits decide saturation up front; the remaining
  // quotient bits come out one per stage by restoring division.
  always_comb begin
    dhi        = dvd[DVD_W-1:Q_W];
    sat0       = DEN_W'(dhi) >= den;
    rem_nxt[0] = sat0 ? '0 : DEN_W'(dhi);
    wrd_nxt[0] = dvd[Q_W-1:0];
    for (int k = 1; k <= Q_W; k++) begin
      tr[k-1]    = {rem_r[k-1], wrd_r[k-1][Q_W-1]};
      ge[k-1]    = tr[k-1] >= {1'b0, den_r[k-1]};
      wrd_nxt[k] = {wrd_r[k-1][Q_W-2:0], ge[k-1]};
    end
    for (int k = 1; k < Q_W; k++) begin
      rem_nxt[k] = ge[k-1] ? DEN_W'(tr[k-1] - {1'b0, den_r[k-1]}) : DEN_W'(tr[k-1]);
    end
    if (sat_r[Q_W]) begin
      mag = neg_r[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}};
    end else begin
      mag = {1'b0, wrd_r[Q_W]};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= rem_nxt[0];
    den_r[0] <= den;
    wrd_r[0] <= wrd_nxt[0];
    sat_r[0] <= sat0;
    neg_r[0] <= neg;
    for (int k = 1; k < Q_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_r[k-1];
    end
    for (int k = 1; k <= Q_W; k++) begin
      wrd_r[k] <= wrd_nxt[k];
      sat_r[k] <= sat_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
    res_r <= neg_r[Q_W] ? -$signed(mag) : $signed(mag);
  end

  assign res = res_r;

endmodule

// Division by the mass denominator, three times a power of two. The power
// of two is a shift; the division by three runs as a 24-bit high and a
// 25-bit low digit, each by reciprocal multiplication. A delay line brings
// the latency up to that of the general divider so the lanes stay aligned.
module tmfe_mdiv
  import tmfe_pkg::*;
(
  input  wire              clk,
  input  wire [DVD_W-1:0]  dvd,
  input  wire              neg,
  output logic signed [OUT_W-1:0] res
);

  localparam int T_W   = DVD_W - MASS_SH;
  localparam int TQ_W  = Q_W + 2;
  localparam int LO_W  = 25;
  localparam int HI_W  = TQ_W - LO_W;
  localparam int QH_W  = Q_W - LO_W;
  localparam int D3_W  = 27;
  localparam int D3_SH = 28;
  localparam logic [D3_W-1:0] D3_MUL = D3_W'((64'd1 << D3_SH) / 3 + 1);
  localparam logic [T_W-1:0]  SAT_T  = T_W'(3) << Q_W;
  localparam int DL = DIV_LAT - 4;

  logic [TQ_W-1:0]         t_r;
  logic [HI_W-1:0]         hi_r;
  logic [LO_W-1:0]         lo_r;
  logic [D3_W-1:0]         qh_r;
  logic [QH_W-1:0]         qh3_r;
  logic [D3_W-1:0]         x3_r;
  logic [Q_W-1:0]          mag_r;
  logic                    sat_r [4];
  logic                    neg_r [4];
  logic [D3_W-1:0]         rem_h, lo_q;
  logic [OUT_W-1:0]        mag;
  logic signed [OUT_W-1:0] dl_r [DL];

  // Exact floor(x / 3) for x below 2^27.
  function automatic logic [D3_W-1:0] div3(input logic [D3_W-1:0] x);
    logic [2*D3_W-1:0] p;
    p = x * D3_MUL;
    return {1'b0, p[2*D3_W-1:D3_SH]};
  endfunction

  always_comb begin
    rem_h = {{(D3_W-HI_W){1'b0}}, hi_r} - {qh_r[D3_W-2:0], 1'b0} - qh_r;
    lo_q  = div3(x3_r);
    if (sat_r[3]) begin
      mag = neg_r[3] ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}};
    end else begin
      mag = {1'b0, mag_r};
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= dvd[MASS_SH +: TQ_W];
    sat_r[0] <= dvd[DVD_W-1:MASS_SH] >= SAT_T;
    neg_r[0] <= neg;

    qh_r <= div3({{(D3_W-HI_W){1'b0}}, t_r[TQ_W-1:LO_W]});
    hi_r <= t_r[TQ_W-1:LO_W];
    lo_r <= t_r[LO_W-1:0];

    x3_r  <= {rem_h[1:0], lo_r};
    qh3_r <= qh_r[QH_W-1:0];

    mag_r <= {qh3_r, lo_q[LO_W-1:0]};

    for (int k = 1; k < 4; k++) begin
      sat_r[k] <= sat_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end

    dl_r[0] <= neg_r[3] ? -$signed(mag) : $signed(mag);
    for (int k = 1; k < DL; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
  end

  assign res = dl_r[DL-1];

endmodule

`default_nettype wire

FILE: rtl/tmfe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tmfe_front
  import tmfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = JOBQ_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire signed [IN_W-1:0]  in_x_first,
  input  wire signed [IN_W-1:0]  in_y_first,
  input  wire signed [IN_W-1:0]  in_x_second,
  input  wire signed [IN_W-1:0]  in_y_second,
  input  wire signed [IN_W-1:0]  in_x_third,
  input  wire signed [IN_W-1:0]  in_y_third,
  input  wire signed [IN_W-1:0]  in_mass_coef,
  input  wire signed [IN_W-1:0]  in_stiff_coef,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [IN_W-1:0]         cfg_data,
  input  wire                    pop,
  output logic                   push,
  output job_t                   push_job
);

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    dif_t [2:0]             dy;
    dif_t [2:0]             dx;
    logic signed [IN_W-1:0] alpha;
    logic signed [IN_W-1:0] beta;
  } geom_t;

  logic [IN_W-1:0]          lim_r;
  logic [PEND_W-1:0]        pend_r, pend_nxt;
  logic                     accept;
  logic                     f0_vld_r, f1_vld_r, f2_vld_r;
  geom_t                    f0_r, f0_nxt, f1_r, f2_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic signed [DET_W-1:0]  det_r, det_nxt, det_neg, lim_s, lim_neg;

  assign cfg_ready = 1'b1;
  // Pending counts items from acceptance until the back pulls them out of
  // the queue, so items still in the front always have a queue slot.
  assign busy      = pend_r == PEND_W'(QUEUE_DEPTH);
  assign accept    = start && !busy;

  always_comb begin
    pend_nxt = pend_r;
    if (accept && !pop) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!accept && pop) begin
      pend_nxt = pend_r - 1'b1;
    end

    f0_nxt.dy[0] = dif_t'(in_y_second) - dif_t'(in_y_third);
    f0_nxt.dy[1] = dif_t'(in_y_third)  - dif_t'(in_y_first);
    f0_nxt.dy[2] = dif_t'(in_y_first)  - dif_t'(in_y_second);
    f0_nxt.dx[0] = dif_t'(in_x_third)  - dif_t'(in_x_second);
    f0_nxt.dx[1] = dif_t'(in_x_first)  - dif_t'(in_x_third);
    f0_nxt.dx[2] = dif_t'(in_x_second) - dif_t'(in_x_first);
    f0_nxt.alpha = in_mass_coef;
    f0_nxt.beta  = in_stiff_coef;

    // detD = dx2*dy1 - dx1*dy2 in terms of the edge differences.
    p1_nxt  = $signed(f0_r.dx[2]) * $signed(f0_r.dy[1]);
    p2_nxt  = $signed(f0_r.dx[1]) * $signed(f0_r.dy[2]);
    det_nxt = DET_W'(p1_r) - DET_W'(p2_r);

    det_neg = -det_r;
    lim_s   = $signed({{(DET_W-IN_W){1'b0}}, lim_r});
    lim_neg = -lim_s;

    push           = f2_vld_r;
    push_job.dy    = f2_r.dy;
    push_job.dx    = f2_r.dx;
    push_job.alpha = f2_r.alpha;
    push_job.beta  = f2_r.beta;
    push_job.adet  = det_r[DET_W-1] ? det_neg[ADET_W-1:0] : det_r[ADET_W-1:0];
    push_job.sing  = (det_r <= lim_s) && (det_r >= lim_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r    <= '0;
      pend_r   <= '0;
      f0_vld_r <= 1'b0;
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lim_r <= cfg_data;
      end
      pend_r   <= pend_nxt;
      f0_vld_r <= accept;
      f1_vld_r <= f0_vld_r;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f0_r  <= f0_nxt;
    f1_r  <= f0_r;
    f2_r  <= f1_r;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    det_r <= det_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/tmfe_jobq.sv
`timescale 1ns / 1ps
`default_nettype none

module tmfe_jobq
  import tmfe_pkg::*;
#(
  parameter int DEPTH = JOBQ_DEPTH
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  job_t  push_job,
  input  wire   pop,
  output logic  head_vld,
  output job_t  head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign head_vld = cnt_r != '0;
  assign head_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CW'(DEPTH)) || pop)
    else $error("job queue written while full");

endmodule

`default_nettype wire

FILE: rtl/tmfe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tmfe_back
  import tmfe_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       head_vld,
  input  job_t                      head_job,
  output logic                      pop,
  output logic                      out_valid,
  output logic [ROW_W-1:0]          out_row_index,
  output logic signed [OUT_W-1:0]   out_stiff_col0,
  output logic signed [OUT_W-1:0]   out_stiff_col1,
  output logic signed [OUT_W-1:0]   out_stiff_col2,
  output logic signed [OUT_W-1:0]   out_mass_col0,
  output logic signed [OUT_W-1:0]   out_mass_col1,
  output logic signed [OUT_W-1:0]   out_mass_col2,
  output logic                      out_singular,
  output logic                      out_last_row
);

  localparam int SP_LEN = 6 + DIV_LAT;

  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
    logic             sing;
    logic             aneg;
    logic             bneg;
  } side_t;

  side_t                    sp_r [SP_LEN];
  side_t                    sp_nxt, osd;
  logic [ROW_W-1:0]         row_r;
  dif_t                     dyi, dxi;
  logic [IN_W-1:0]          amag, bmag;

  logic signed [PROD_W-1:0] sy_r [3];
  logic signed [PROD_W-1:0] sx_r [3];
  logic [PP_W-1:0]          pml_r, pmh_r;
  logic [ADET_W-1:0]        adet_r [6];
  logic [IN_W-1:0]          bmag_r [3];
  logic signed [DET_W-1:0]  n_r [3];
  logic [NPROD_W-1:0]       pm_r;
  logic [NMAG_W-1:0]        nmag_r [3];
  logic [2:0]               sneg_r [4];
  logic [DVD_W-1:0]         dmd_r [4];
  logic [DVD_W-1:0]         dmo_r [4];
  logic [PP_W-1:0]          sl_r [3];
  logic [PP_W-1:0]          sh_r [3];
  logic [NPROD_W-1:0]       np_r [3];
  logic [DVD_W-1:0]         dvs_r [3];

  logic signed [OUT_W-1:0]  sres [3];
  logic signed [OUT_W-1:0]  mres_d, mres_o;

  logic                     ovld_r, osing_r, olast_r;
  logic [ROW_W-1:0]         orow_r;
  logic signed [OUT_W-1:0]  ostf_r [3];
  logic signed [OUT_W-1:0]  omas_r [3];

  // One row of the head job enters the datapath every cycle head_vld is high.
  assign pop = head_vld && (row_r == ROW_LAST);

  always_comb begin
    case (row_r)
      ROW_FIRST: begin
        dyi = head_job.dy[0];
        dxi = head_job.dx[0];
      end
      ROW_MID: begin
        dyi = head_job.dy[1];
        dxi = head_job.dx[1];
      end
      default: begin
        dyi = head_job.dy[2];
        dxi = head_job.dx[2];
      end
    endcase
    amag = head_job.alpha[IN_W-1] ? IN_W'(-head_job.alpha) : head_job.alpha;
    bmag = head_job.beta[IN_W-1]  ? IN_W'(-head_job.beta)  : head_job.beta;

    sp_nxt.vld  = head_vld;
    sp_nxt.row  = row_r;
    sp_nxt.sing = head_job.sing;
    sp_nxt.aneg = head_job.alpha[IN_W-1];
    sp_nxt.bneg = head_job.beta[IN_W-1];

    osd = sp_r[SP_LEN-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= ROW_FIRST;
      ovld_r <= 1'b0;
      for (int k = 0; k < SP_LEN; k++) begin
        sp_r[k] <= '0;
      end
    end else begin
      if (head_vld) begin
        row_r <= (row_r == ROW_LAST) ? ROW_FIRST : row_r + 1'b1;
      end
      sp_r[0] <= sp_nxt;
      for (int k = 1; k < SP_LEN; k++) begin
        sp_r[k] <= sp_r[k-1];
      end
      ovld_r <= osd.vld;
    end
  end

  // Numerator pipeline: products, sums, magnitudes, split multiplies and
  // the rounded dividends for the divider lanes.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sy_r[j] <= $signed(dyi) * $signed(head_job.dy[j]);
      sx_r[j] <= $signed(dxi) * $signed(head_job.dx[j]);
    end
    pml_r     <= amag * head_job.adet[SPLIT_W-1:0];
    pmh_r     <= amag * head_job.adet[ADET_W-1:SPLIT_W];
    adet_r[0] <= head_job.adet;
    bmag_r[0] <= bmag;

    for (int j = 0; j < 3; j++) begin
      n_r[j] <= DET_W'(sy_r[j]) + DET_W'(sx_r[j]);
    end
    pm_r      <= NPROD_W'(pml_r) + (NPROD_W'(pmh_r) << SPLIT_W);
    adet_r[1] <= adet_r[0];
    bmag_r[1] <= bmag_r[0];

    for (int j = 0; j < 3; j++) begin
      nmag_r[j]    <= n_r[j][DET_W-1] ? NMAG_W'(-n_r[j]) : NMAG_W'(n_r[j]);
      sneg_r[0][j] <= sp_r[1].bneg ^ n_r[j][DET_W-1];
    end
    dmd_r[0]  <= DVD_W'({pm_r, 1'b0}) + DVD_W'(MASS_HALF);
    dmo_r[0]  <= DVD_W'(pm_r) + DVD_W'(MASS_HALF);
    adet_r[2] <= adet_r[1];
    bmag_r[2] <= bmag_r[1];

    for (int j = 0; j < 3; j++) begin
      sl_r[j] <= bmag_r[2] * nmag_r[j][SPLIT_W-1:0];
      sh_r[j] <= bmag_r[2] * nmag_r[j][NMAG_W-1:SPLIT_W];
    end
    adet_r[3] <= adet_r[2];

    for (int j = 0; j < 3; j++) begin
      np_r[j] <= NPROD_W'(sl_r[j]) + (NPROD_W'(sh_r[j]) << SPLIT_W);
    end
    adet_r[4] <= adet_r[3];

    // Adding |detD| is half of the divisor 2|detD|, for round to nearest.
    for (int j = 0; j < 3; j++) begin
      dvs_r[j] <= (DVD_W'(np_r[j]) << STIFF_SH) + DVD_W'(adet_r[4]);
    end
    adet_r[5] <= adet_r[4];

    for (int k = 1; k < 4; k++) begin
      sneg_r[k] <= sneg_r[k-1];
      dmd_r[k]  <= dmd_r[k-1];
      dmo_r[k]  <= dmo_r[k-1];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_sdiv
    tmfe_div u_sdiv (
      .clk (clk),
      .dvd (dvs_r[j]),
      .den ({adet_r[5], 1'b0}),
      .neg (sneg_r[3][j]),
      .res (sres[j])
    );
  end

  tmfe_mdiv u_mdiag (
    .clk (clk),
    .dvd (dmd_r[3]),
    .neg (sp_r[5].aneg),
    .res (mres_d)
  );

  tmfe_mdiv u_moff (
    .clk (clk),
    .dvd (dmo_r[3]),
    .neg (sp_r[5].aneg),
    .res (mres_o)
  );

  always_ff @(posedge clk) begin
    orow_r  <= osd.row;
    osing_r <= osd.sing;
    olast_r <= osd.row == ROW_LAST;
    for (int j = 0; j < 3; j++) begin
      ostf_r[j] <= osd.sing ? '0 : sres[j];
      if (osd.sing) begin
        omas_r[j] <= '0;
      end else begin
        omas_r[j] <= (osd.row == ROW_W'(j)) ? mres_d : mres_o;
      end
    end
  end

  assign out_valid      = ovld_r;
  assign out_row_index  = orow_r;
  assign out_singular   = osing_r;
  assign out_last_row   = olast_r;
  assign out_stiff_col0 = ostf_r[0];
  assign out_stiff_col1 = ostf_r[1];
  assign out_stiff_col2 = ostf_r[2];
  assign out_mass_col0  = omas_r[0];
  assign out_mass_col1  = omas_r[1];
  assign out_mass_col2  = omas_r[2];

  a_row_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_index == ROW_FIRST) |=> out_valid && (out_row_index == ROW_MID))
    else $error("row 0 not followed by row 1");

  a_row_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_index == ROW_MID) |=> out_valid && out_last_row)
    else $error("row 1 not followed by the last row");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> (out_stiff_col0 == '0) && (out_stiff_col1 == '0) &&
      (out_stiff_col2 == '0) && (out_mass_col0 == '0) && (out_mass_col1 == '0) &&
      (out_mass_col2 == '0))
    else $error("singular row carries nonzero entries");

  a_sing_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=> out_singular == $past(out_singular))
    else $error("singular flag changed within one triangle");

endmodule

`default_nettype wire

FILE: rtl/p1_triangle_element_matrices_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Stiffness and mass matrices of a linear triangle, one row per result.
// Input: an item is taken at a rising edge with start high and busy low;
// the in_ ports carry three Q12.12 vertices and the two coefficients.
// Configuration: cfg_data is written into the singular limit at an edge
// with cfg_valid and cfg_ready high; cfg_ready is always high.
// Results: each item gives three results, rows 0, 1 and 2 on consecutive
// cycles, each shown for one cycle with out_valid high. The receiver
// cannot stall, so nothing ever waits at the output.
// Path: with an empty queue, row 0 passes through three front stages, the
// job queue, six numerator stages and the 49-stage bit-per-stage divider
// lanes, then the output register.
// Throughput: the back end issues one row per cycle into the divider lanes
// and takes up a new item only once all three rows of the last are issued.
// busy rises once four items are accepted but not yet taken up by the back
// end, so bursts of up to four are absorbed at one per cycle.
// Reset: synchronous, active low; it clears the singular limit to zero,
// empties the queue and drops all in-flight items.

module p1_triangle_element_matrices_unit
  import tmfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = JOBQ_DEPTH
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire signed [IN_W-1:0]    in_x_first,
  input  wire signed [IN_W-1:0]    in_y_first,
  input  wire signed [IN_W-1:0]    in_x_second,
  input  wire signed [IN_W-1:0]    in_y_second,
  input  wire signed [IN_W-1:0]    in_x_third,
  input  wire signed [IN_W-1:0]    in_y_third,
  input  wire signed [IN_W-1:0]    in_mass_coef,
  input  wire signed [IN_W-1:0]    in_stiff_coef,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [IN_W-1:0]           cfg_data,
  output logic                     out_valid,
  output logic [ROW_W-1:0]         out_row_index,
  output logic signed [OUT_W-1:0]  out_stiff_col0,
  output logic signed [OUT_W-1:0]  out_stiff_col1,
  output logic signed [OUT_W-1:0]  out_stiff_col2,
  output logic signed [OUT_W-1:0]  out_mass_col0,
  output logic signed [OUT_W-1:0]  out_mass_col1,
  output logic signed [OUT_W-1:0]  out_mass_col2,
  output logic                     out_singular,
  output logic                     out_last_row
);

  logic push, pop, head_vld;
  job_t push_job, head_job;

  tmfe_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_x_first    (in_x_first),
    .in_y_first    (in_y_first),
    .in_x_second   (in_x_second),
    .in_y_second   (in_y_second),
    .in_x_third    (in_x_third),
    .in_y_third    (in_y_third),
    .in_mass_coef  (in_mass_coef),
    .in_stiff_coef (in_stiff_coef),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .pop           (pop),
    .push          (push),
    .push_job      (push_job)
  );

  tmfe_jobq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_vld (head_vld),
    .head_job (head_job)
  );

  tmfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_vld       (head_vld),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_row_index  (out_row_index),
    .out_stiff_col0 (out_stiff_col0),
    .out_stiff_col1 (out_stiff_col1),
    .out_stiff_col2 (out_stiff_col2),
    .out_mass_col0  (out_mass_col0),
    .out_mass_col1  (out_mass_col1),
    .out_mass_col2  (out_mass_col2),
    .out_singular   (out_singular),
    .out_last_row   (out_last_row)
  );

endmodule

`default_nettype wire

FILE: bench/p1_triangle_element_matrices_unit_test.sv
`timescale 1ns / 1ps

module p1_triangle_element_matrices_unit_test;
  import tmfe_pkg::*;

  localparam logic [IN_W-1:0] C_MAX = 24'h7FFFFF;
  localparam logic [IN_W-1:0] C_MIN = 24'h800000;
  localparam logic [IN_W-1:0] C_ONE = 24'h001000;
  localparam logic [IN_W-1:0] C_TWO = 24'h002000;
  localparam int N_DIR = 14;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [127:0] POS_SAT = (128'd1 << 47) - 1;
  localparam logic [127:0] NEG_SAT = 128'd1 << 47;

  typedef struct packed {
    logic signed [IN_W-1:0] x0, y0, x1, y1, x2, y2, alpha, beta;
  } tri_t;

  typedef struct packed {
    tri_t t;
    logic zero_rows;
  } dir_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic signed [OUT_W-1:0] stiff [3];
    logic signed [OUT_W-1:0] mass [3];
    logic sing;
    logic last;
  } row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tri_t drv;
  logic cfg_valid;
  logic cfg_ready;
  logic [IN_W-1:0] cfg_data;
  logic out_valid;
  logic [ROW_W-1:0] out_row_index;
  logic signed [OUT_W-1:0] out_stiff_col0, out_stiff_col1, out_stiff_col2;
  logic signed [OUT_W-1:0] out_mass_col0, out_mass_col1, out_mass_col2;
  logic out_singular;
  logic out_last_row;

  row_t pending_rows [$];
  logic [IN_W-1:0] limit_copy;
  int errors;
  int cycles;
  int idle_pct;

  // Rows whose expectation is typed in are singular triangles: all entries zero.
  dir_t dir_tab [N_DIR] = '{
    '{'{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0}, 1'b1},
    '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1},
    '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b1},
    '{'{24'h0, 24'h0, C_ONE, 24'h0, 24'h0, C_ONE, C_ONE, C_ONE}, 1'b0},
    '{'{24'h0, 24'h0, C_ONE, 24'h0, 24'h0, C_ONE, C_MIN, C_MIN}, 1'b0},
    '{'{24'h0, 24'h0, C_ONE, 24'h0, 24'h0, C_ONE, C_MAX, C_MAX}, 1'b0},
    '{'{C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}, 1'b0},
    '{'{C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN}, 1'b0},
    '{'{C_MIN, 24'h0, C_MAX, 24'h0, 24'h0, 24'h1, C_MIN, C_MAX}, 1'b0},
    '{'{C_MIN, 24'h0, C_MAX, 24'h0, 24'h0, 24'h1, C_MAX, C_MIN}, 1'b0},
    '{'{24'h0, 24'h0, 24'h0, C_ONE, C_ONE, 24'h0, C_ONE, C_ONE}, 1'b0},
    '{'{24'h0, 24'h0, C_ONE, C_ONE, C_TWO, C_TWO, C_ONE, C_ONE}, 1'b1},
    '{'{24'h0, 24'h0, 24'h1, 24'h0, 24'h0, 24'h1, C_ONE, C_ONE}, 1'b0},
    '{'{24'h0, 24'h0, C_ONE, 24'h0, 24'h0, C_ONE, 24'h0, 24'h0}, 1'b0}
  };

  p1_triangle_element_matrices_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_first(drv.x0), .in_y_first(drv.y0),
    .in_x_second(drv.x1), .in_y_second(drv.y1),
    .in_x_third(drv.x2), .in_y_third(drv.y2),
    .in_mass_coef(drv.alpha), .in_stiff_coef(drv.beta),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_row_index(out_row_index),
    .out_stiff_col0(out_stiff_col0), .out_stiff_col1(out_stiff_col1),
    .out_stiff_col2(out_stiff_col2), .out_mass_col0(out_mass_col0),
    .out_mass_col1(out_mass_col1), .out_mass_col2(out_mass_col2),
    .out_singular(out_singular), .out_last_row(out_last_row)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rounds mag/den to nearest, ties away from zero, then clamps and signs.
  function automatic logic [OUT_W-1:0] rounded_entry(logic [127:0] mag,
                                                     logic [127:0] den, bit neg);
    logic [127:0] q;
    q = (mag + (den >> 1)) / den;
    if (neg && q > NEG_SAT) q = NEG_SAT;
    if (!neg && q > POS_SAT) q = POS_SAT;
    return neg ? OUT_W'(-q) : q[OUT_W-1:0];
  endfunction

  function automatic void push_element_rows(tri_t t);
    longint x0, y0, x1, y1, x2, y2, al, be, det, n;
    longint dy [3];
    longint dx [3];
    logic [127:0] adet, abe, aal, an;
    row_t r;
    bit sing;
    x0 = t.x0; y0 = t.y0; x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2;
    al = t.alpha; be = t.beta;
    det = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    adet = det < 0 ? -det : det;
    abe = be < 0 ? -be : be;
    aal = al < 0 ? -al : al;
    sing = adet <= limit_copy;
    dy[0] = y1 - y2; dy[1] = y2 - y0; dy[2] = y0 - y1;
    dx[0] = x2 - x1; dx[1] = x0 - x2; dx[2] = x1 - x0;
    for (int i = 0; i < 3; i++) begin
      r.row = ROW_W'(i);
      for (int j = 0; j < 3; j++) begin
        r.stiff[j] = '0;
        r.mass[j] = '0;
        if (!sing) begin
          n = dy[i] * dy[j] + dx[i] * dx[j];
          an = n < 0 ? -n : n;
          r.stiff[j] = rounded_entry((abe * an) << 12, adet * 2, (be < 0) != (n < 0));
          r.mass[j] = rounded_entry(aal * adet * (i == j ? 2 : 1), MASS_DEN, al < 0);
        end
      end
      r.sing = sing;
      r.last = (ROW_W'(i) == ROW_LAST);
      pending_rows.push_back(r);
    end
  endfunction

  function automatic void push_zero_rows();
    row_t r;
    for (int i = 0; i < 3; i++) begin
      r.row = ROW_W'(i);
      for (int j = 0; j < 3; j++) begin
        r.stiff[j] = '0;
        r.mass[j] = '0;
      end
      r.sing = 1'b1;
      r.last = (i == 2);
      pending_rows.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [OUT_W-1:0] exp_v,
                                      logic [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    row_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_rows.size() == 0) begin
        $error("row_index: no row expected, got %0d", out_row_index);
        errors++;
      end else begin
        e = pending_rows.pop_front();
        check_field("row_index", e.row, out_row_index);
        check_field("stiff_col0", e.stiff[0], out_stiff_col0);
        check_field("stiff_col1", e.stiff[1], out_stiff_col1);
        check_field("stiff_col2", e.stiff[2], out_stiff_col2);
        check_field("mass_col0", e.mass[0], out_mass_col0);
        check_field("mass_col1", e.mass[1], out_mass_col1);
        check_field("mass_col2", e.mass[2], out_mass_col2);
        check_field("singular", e.sing, out_singular);
        check_field("last_row", e.last, out_last_row);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_limit(logic [IN_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    limit_copy = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // The item is accepted at the first rising edge with busy low.
  task automatic send_item(tri_t t, bit zero_rows);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    drv = t;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (zero_rows) push_zero_rows();
    else push_element_rows(t);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] small_coord();
    return IN_W'($signed($urandom_range(0, 16383)) - 8192);
  endfunction

  function automatic tri_t random_triangle();
    tri_t t;
    logic [IN_W-1:0] dxv, dyv;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5, 6, 7: begin
        t.x0 = small_coord(); t.y0 = small_coord();
        t.x1 = small_coord(); t.y1 = small_coord();
        t.x2 = small_coord(); t.y2 = small_coord();
        if ($urandom_range(1)) begin
          t.alpha = small_coord();
          t.beta = small_coord();
        end
      end
      default: begin
        // Collinear or nearly collinear vertices.
        dxv = small_coord(); dyv = small_coord();
        t.x0 = small_coord(); t.y0 = small_coord();
        t.x1 = t.x0 + dxv; t.y1 = t.y0 + dyv;
        t.x2 = t.x1 + dxv; t.y2 = t.y1 + dyv + IN_W'($urandom_range(0, 2));
      end
    endcase
    return t;
  endfunction

  task automatic random_items(int count);
    for (int k = 0; k < count; k++) send_item(random_triangle(), 1'b0);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 33;
    rst_n = 1'b0;
    start = 1'b0;
    drv = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    limit_copy = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_limit('0);
    for (int k = 0; k < N_DIR; k++) send_item(dir_tab[k].t, dir_tab[k].zero_rows);
    random_items(60);
    wait_drained();

    idle_pct = 83;
    write_limit(24'hFFFFFF);
    random_items(60);
    wait_drained();

    idle_pct = 0;
    write_limit(IN_W'($urandom));
    random_items(35);
    wait_drained();
    random_items(35);
    wait_drained();

    write_limit(24'h1);
    random_items(10);
    wait_drained();

    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tmfe_pkg.sv
rtl/tmfe_div.sv
rtl/tmfe_front.sv
rtl/tmfe_jobq.sv
rtl/tmfe_back.sv
rtl/p1_triangle_element_matrices_unit.sv
bench/p1_triangle_element_matrices_unit_test.sv
